FILE: rtl/bpb_pkg.sv
// ----------------------------------------------------------------------------
// bpb_pkg
// Shared sizes, codes and types for the branch prediction buffer.
// ----------------------------------------------------------------------------
package bpb_pkg;

  localparam int ENTRIES = 256;
  localparam int WAYS    = 4;
  localparam int NSETS   = ENTRIES / WAYS;
  localparam int SET_W   = $clog2(NSETS);
  localparam int WAY_W   = $clog2(WAYS);
  localparam int TAG_W   = 32;
  localparam int VAL_W   = 8;
  localparam int CTR_W   = 8;
  localparam int CFG_W   = 2;

  localparam logic [1:0] ORG_DISABLED = 2'd0;
  localparam logic [1:0] ORG_DIRECT   = 2'd1;
  localparam logic [1:0] ORG_ASSOC    = 2'd2;

  localparam logic REPL_SHIFT  = 1'b0;
  localparam logic REPL_RANDOM = 1'b1;

  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  localparam logic CFG_ORGANIZATION     = 1'b0;
  localparam logic CFG_REPLACEMENT_MODE = 1'b1;

  typedef struct packed {
    logic        func;
    logic [31:0] address;
    logic [7:0]  new_value;
  } in_word_t;

  typedef struct packed {
    logic [7:0] entry_value;
    logic       hit;
    logic [3:0] way;
    logic       evicted;
  } out_word_t;

  typedef logic [WAYS-1:0][TAG_W-1:0] tag_row_t;
  typedef logic [WAYS-1:0][VAL_W-1:0] val_row_t;

  typedef struct packed {
    tag_row_t tags;
    val_row_t vals;
  } row_t;

  localparam int ROW_W = $bits(row_t);

  typedef struct packed {
    logic capture;
    logic update;
  } cmd_t;

endpackage

FILE: rtl/bpb_ram.sv
// ----------------------------------------------------------------------------
// bpb_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module bpb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/bpb_ctrl.sv
// ----------------------------------------------------------------------------
// bpb_ctrl
// Sequencer: accept a word, look up its set, update and present the result.
// ----------------------------------------------------------------------------
module bpb_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output bpb_pkg::cmd_t cmd
);

  localparam logic S_IDLE   = 1'b0;
  localparam logic S_LOOKUP = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  always_comb begin
    in_ready      = 1'b0;
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        in_ready    = !out_valid_r || out_ready;
        cmd.capture = in_valid && in_ready;
        if (cmd.capture) begin
          state_nxt = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        cmd.update    = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: rtl/bpb_datapath.sv
// ----------------------------------------------------------------------------
// bpb_datapath
// Set store, tag compare, way allocation, write-back and result register.
// ----------------------------------------------------------------------------
module bpb_datapath (
  input  logic                      clk,
  input  logic                      rst_n,
  input  bpb_pkg::cmd_t             cmd,
  input  bpb_pkg::in_word_t         in_word,
  output bpb_pkg::out_word_t        out_word,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [bpb_pkg::CFG_W-1:0] cfg_wdata
);

  logic [1:0]                  org_r;
  logic                        repl_r;
  logic [bpb_pkg::CTR_W-1:0]   ctr_r;
  logic [bpb_pkg::NSETS-1:0]   valid_r;
  bpb_pkg::in_word_t           item_r;
  logic [bpb_pkg::SET_W-1:0]   row_idx_r;
  bpb_pkg::out_word_t          out_r, out_nxt;

  logic [bpb_pkg::SET_W-1:0]   rd_idx;
  logic [bpb_pkg::ROW_W-1:0]   ram_rdata;
  bpb_pkg::row_t               row_cur, row_new;
  logic                        row_we;
  logic [bpb_pkg::WAYS-1:0]    match, empty;
  logic [bpb_pkg::WAY_W-1:0]   mway, eway, chosen, dway;
  logic                        any_match, any_empty;

  assign rd_idx = (org_r == bpb_pkg::ORG_DIRECT)
                ? in_word.address[2 + bpb_pkg::WAY_W +: bpb_pkg::SET_W]
                : in_word.address[2 +: bpb_pkg::SET_W];

  bpb_ram #(
    .WIDTH (bpb_pkg::ROW_W),
    .DEPTH (bpb_pkg::NSETS)
  ) u_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_idx_r),
    .wdata (row_new),
    .re    (cmd.capture),
    .raddr (rd_idx),
    .rdata (ram_rdata)
  );

  always_comb begin
    row_cur   = valid_r[row_idx_r] ? bpb_pkg::row_t'(ram_rdata) : '0;
    row_new   = row_cur;
    row_we    = 1'b0;
    out_nxt   = '0;
    mway      = '0;
    eway      = '0;
    chosen    = '0;
    dway      = item_r.address[2 +: bpb_pkg::WAY_W];
    for (int w = 0; w < bpb_pkg::WAYS; w++) begin
      match[w] = row_cur.tags[w] == item_r.address;
      empty[w] = row_cur.tags[w] == '0;
    end
    for (int w = bpb_pkg::WAYS - 1; w >= 0; w--) begin
      if (match[w]) mway = bpb_pkg::WAY_W'(w);
      if (empty[w]) eway = bpb_pkg::WAY_W'(w);
    end
    any_match = |match;
    any_empty = |empty;

    case (org_r)
      bpb_pkg::ORG_DIRECT: begin
        out_nxt.hit         = 1'b1;
        out_nxt.entry_value = row_cur.vals[dway];
        if (item_r.func == bpb_pkg::FUNC_WRITE) begin
          row_we              = 1'b1;
          row_new.vals[dway]  = item_r.new_value;
          out_nxt.entry_value = item_r.new_value;
        end
      end
      bpb_pkg::ORG_ASSOC: begin
        if (item_r.func == bpb_pkg::FUNC_READ) begin
          if (any_match) begin
            out_nxt.entry_value = row_cur.vals[mway];
            out_nxt.hit         = 1'b1;
            out_nxt.way         = 4'(mway);
          end
        end else begin
          row_we              = 1'b1;
          out_nxt.entry_value = item_r.new_value;
          if (any_match) begin
            chosen      = mway;
            out_nxt.hit = 1'b1;
          end else if (any_empty) begin
            chosen = eway;
          end else begin
            out_nxt.evicted = 1'b1;
            if (repl_r == bpb_pkg::REPL_RANDOM) begin
              chosen = ctr_r[bpb_pkg::WAY_W-1:0];
            end else begin
              for (int w = 0; w < bpb_pkg::WAYS - 1; w++) begin
                row_new.tags[w] = row_cur.tags[w+1];
                row_new.vals[w] = row_cur.vals[w+1];
              end
              chosen = bpb_pkg::WAY_W'(bpb_pkg::WAYS - 1);
            end
          end
          row_new.tags[chosen] = item_r.address;
          row_new.vals[chosen] = item_r.new_value;
          out_nxt.way          = 4'(chosen);
        end
      end
      default: out_nxt = '0;
    endcase
    row_we = row_we && cmd.update;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_r   <= bpb_pkg::ORG_ASSOC;
      repl_r  <= bpb_pkg::REPL_SHIFT;
      ctr_r   <= '0;
      valid_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          bpb_pkg::CFG_ORGANIZATION:     org_r  <= cfg_wdata;
          bpb_pkg::CFG_REPLACEMENT_MODE: repl_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (cmd.update) begin
        ctr_r <= ctr_r + 1'b1;
      end
      if (row_we) begin
        valid_r[row_idx_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r    <= in_word;
      row_idx_r <= rd_idx;
    end
    if (cmd.update) begin
      out_r <= out_nxt;
    end
  end

  assign out_word = out_r;

endmodule

FILE: rtl/branch_prediction_buffer_core.sv
// ----------------------------------------------------------------------------
// branch_prediction_buffer_core
// Set-associative / direct-mapped branch prediction buffer, 8-bit entries.
// ----------------------------------------------------------------------------
// The set row of a word is read from the RAM on the accept edge and is
// compared, updated and written back in the following cycle, when the
// result is loaded into the output register. The next word is accepted
// in the cycle after that at the earliest, and only once the previous result
// is taken (at the latest on the same edge), so the block takes no new word
// while the last one is still being looked up. Each set keeps one valid
// flop cleared by reset, so the buffer is usable straight out of reset with
// no clearing pass.
module branch_prediction_buffer_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  bpb_pkg::in_word_t         in_word,
  output logic                      out_valid,
  input  logic                      out_ready,
  output bpb_pkg::out_word_t        out_word,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [bpb_pkg::CFG_W-1:0] cfg_wdata
);

  bpb_pkg::cmd_t cmd;

  bpb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  bpb_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_word   (in_word),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

endmodule

FILE: tb/sv/branch_prediction_buffer_core_tb.sv
// ----------------------------------------------------------------------------
// branch_prediction_buffer_core_tb
// Self-checking bench for the branch prediction buffer core. A tracker class
// keeps its own copy of the tag and value stores and the victim counter,
// predicts the result word of every accepted lookup and checks the returned
// words in order. The bench runs directed lookups, then random lookups over
// all organisation and replacement settings. Both handshakes idle at random,
// and the receiver holds off once so that the core backs up.
// ----------------------------------------------------------------------------
module branch_prediction_buffer_core_tb;
  import bpb_pkg::*;

  localparam logic [1:0]  ORG_UNUSED  = 2'd3;
  localparam logic [31:0] SET_BASE    = 32'h1000_0040;
  localparam logic [31:0] WAY_STEP    = 32'h0000_0100;
  localparam int          POOL_SIZE   = 16;
  localparam int          CYCLE_LIMIT = 300000;

  class prediction_tracker;
    logic [TAG_W-1:0] tag_store [ENTRIES];
    logic [VAL_W-1:0] value_store [ENTRIES];
    logic [CTR_W-1:0] victim_ctr;
    logic [1:0]       organization;
    logic             replacement;
    out_word_t        pending_lookups [$];
    int               mismatches;

    function new();
      for (int i = 0; i < ENTRIES; i++) begin
        tag_store[i]   = '0;
        value_store[i] = '0;
      end
      victim_ctr   = '0;
      organization = ORG_ASSOC;
      replacement  = REPL_SHIFT;
      mismatches   = 0;
    endfunction

    function void configure(logic [1:0] org, logic repl);
      organization = org;
      replacement  = repl;
    endfunction

    function int pending();
      return pending_lookups.size();
    endfunction

    function void note_word(in_word_t w);
      out_word_t r;
      int        base;
      int        slot;
      r = '0;
      if (organization == ORG_DIRECT) begin
        slot = (w.address >> 2) % ENTRIES;
        if (w.func == FUNC_WRITE)
          value_store[slot] = w.new_value;
        r.entry_value = value_store[slot];
        r.hit         = 1'b1;
      end else if (organization == ORG_ASSOC) begin
        base = ((w.address >> 2) % NSETS) * WAYS;
        slot = -1;
        for (int i = 0; i < WAYS; i++)
          if (slot < 0 && tag_store[base + i] == w.address) slot = i;
        if (w.func == FUNC_READ) begin
          if (slot >= 0) begin
            r.entry_value = value_store[base + slot];
            r.hit         = 1'b1;
            r.way         = 4'(slot);
          end
        end else begin
          if (slot >= 0) begin
            r.hit = 1'b1;
          end else begin
            for (int i = 0; i < WAYS; i++)
              if (slot < 0 && tag_store[base + i] == '0) slot = i;
            if (slot < 0) begin
              r.evicted = 1'b1;
              if (replacement == REPL_RANDOM) begin
                slot = victim_ctr % WAYS;
              end else begin
                for (int i = 0; i < WAYS - 1; i++) begin
                  tag_store[base + i]   = tag_store[base + i + 1];
                  value_store[base + i] = value_store[base + i + 1];
                end
                slot = WAYS - 1;
              end
            end
            tag_store[base + slot] = w.address;
          end
          value_store[base + slot] = w.new_value;
          r.entry_value            = w.new_value;
          r.way                    = 4'(slot);
        end
      end
      victim_ctr = victim_ctr + 1'b1;
      pending_lookups.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0h got %0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_word(out_word_t got);
      out_word_t want;
      if (pending_lookups.size() == 0) begin
        $display("%0t: result word with none expected, expected nothing got %h", $time, got);
        mismatches++;
        return;
      end
      want = pending_lookups.pop_front();
      compare_field("entry_value", 32'(want.entry_value), 32'(got.entry_value));
      compare_field("hit", 32'(want.hit), 32'(got.hit));
      compare_field("way", 32'(want.way), 32'(got.way));
      compare_field("evicted", 32'(want.evicted), 32'(got.evicted));
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_word;
  logic      cfg_we;
  logic      cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  prediction_tracker tracker;
  bit          gaps_on;
  bit          rx_hold_req;
  int          cycles;
  logic [31:0] addr_pool [POOL_SIZE];

  branch_prediction_buffer_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("%0t: timeout after %0d cycles", $time, cycles);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready)
        tracker.check_word(out_word);
      if (rx_hold_req) begin
        hold_left   = 80;
        rx_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !(gaps_on && $urandom_range(99) < 15);
      end
    end
  end

  task automatic send_word(input in_word_t w);
    while (gaps_on && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
    tracker.note_word(w);
  endtask

  task automatic set_mode(input logic [1:0] org, input logic repl);
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ORGANIZATION;
    cfg_wdata <= org;
    @(posedge clk);
    cfg_index <= CFG_REPLACEMENT_MODE;
    cfg_wdata <= CFG_W'(repl);
    tracker.configure(org, repl);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic in_word_t random_word();
    in_word_t w;
    int       pick;
    pick        = $urandom_range(99);
    w.func      = 1'($urandom_range(1));
    w.new_value = 8'($urandom);
    if (pick < 10)
      w.address = $urandom;
    else if (pick < 13)
      w.address = '0;
    else if (pick < 15)
      w.address = '1;
    else
      w.address = addr_pool[$urandom_range(POOL_SIZE - 1)];
    return w;
  endfunction

  task automatic run_phase(input logic [1:0] org, input logic repl, input int count,
                           input bit with_gaps, input bit squeeze);
    set_mode(org, repl);
    gaps_on = with_gaps;
    if (squeeze) rx_hold_req = 1'b1;
    for (int i = 0; i < count; i++)
      send_word(random_word());
  endtask

  initial begin
    logic [5:0] set_a;
    logic [5:0] set_b;
    tracker     = new();
    gaps_on     = 1'b1;
    rx_hold_req = 1'b0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_word   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_ORGANIZATION;
    cfg_wdata <= '0;
    set_a = 6'($urandom);
    set_b = 6'($urandom);
    for (int i = 0; i < POOL_SIZE; i++) begin
      addr_pool[i] = $urandom;
      addr_pool[i][7:2] = (i < POOL_SIZE / 2) ? set_a : set_b;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_mode(ORG_ASSOC, REPL_SHIFT);
    send_word(in_word_t'{FUNC_READ,  SET_BASE,                8'h00});
    send_word(in_word_t'{FUNC_WRITE, SET_BASE,                8'hFF});
    send_word(in_word_t'{FUNC_READ,  SET_BASE,                8'h00});
    send_word(in_word_t'{FUNC_WRITE, SET_BASE + WAY_STEP,     8'h00});
    send_word(in_word_t'{FUNC_WRITE, SET_BASE + 2 * WAY_STEP, 8'h5A});
    send_word(in_word_t'{FUNC_WRITE, SET_BASE + 3 * WAY_STEP, 8'hA5});
    send_word(in_word_t'{FUNC_WRITE, SET_BASE,                8'h11});
    send_word(in_word_t'{FUNC_WRITE, SET_BASE + 4 * WAY_STEP, 8'h33});
    send_word(in_word_t'{FUNC_READ,  SET_BASE,                8'hFF});
    send_word(in_word_t'{FUNC_READ,  SET_BASE + 4 * WAY_STEP, 8'h00});
    send_word(in_word_t'{FUNC_READ,  32'h0000_0000,           8'h00});
    send_word(in_word_t'{FUNC_WRITE, 32'h0000_0000,           8'h77});
    send_word(in_word_t'{FUNC_WRITE, 32'hFFFF_FFFF,           8'h80});
    send_word(in_word_t'{FUNC_READ,  32'hFFFF_FFFF,           8'h00});
    set_mode(ORG_ASSOC, REPL_RANDOM);
    send_word(in_word_t'{FUNC_WRITE, SET_BASE + 5 * WAY_STEP, 8'h01});
    send_word(in_word_t'{FUNC_READ,  SET_BASE + 5 * WAY_STEP, 8'h00});
    set_mode(ORG_DIRECT, REPL_SHIFT);
    send_word(in_word_t'{FUNC_WRITE, 32'h0000_03FC,           8'hC3});
    send_word(in_word_t'{FUNC_READ,  32'h0000_07FC,           8'h00});
    set_mode(ORG_DISABLED, REPL_RANDOM);
    send_word(in_word_t'{FUNC_READ,  SET_BASE + 4 * WAY_STEP, 8'h00});
    send_word(in_word_t'{FUNC_WRITE, SET_BASE,                8'h44});
    set_mode(ORG_UNUSED, REPL_SHIFT);
    send_word(in_word_t'{FUNC_WRITE, SET_BASE,                8'h55});
    send_word(in_word_t'{FUNC_READ,  SET_BASE + 4 * WAY_STEP, 8'h00});

    run_phase(ORG_ASSOC,    REPL_SHIFT,  200, 1'b1, 1'b1);
    run_phase(ORG_ASSOC,    REPL_RANDOM, 180, 1'b1, 1'b0);
    run_phase(ORG_DIRECT,   REPL_RANDOM, 100, 1'b1, 1'b0);
    run_phase(ORG_ASSOC,    REPL_SHIFT,  150, 1'b0, 1'b0);
    run_phase(ORG_DISABLED, REPL_SHIFT,   40, 1'b1, 1'b0);
    run_phase(ORG_UNUSED,   REPL_RANDOM,  40, 1'b1, 1'b0);
    run_phase(ORG_ASSOC,    REPL_RANDOM, 100, 1'b1, 1'b0);

    // drain, then allow stray words to show up
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (tracker.mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
